/* hw/rtl/acm_pkg.sv */
package acm_pkg;

    localparam int NODES      = 1024;
    localparam int ALPHABET   = 26;
    localparam int MAX_DEPTH  = 32;
    localparam int RESULT_CAP = 32;

    localparam int NODE_W  = $clog2(NODES);
    localparam int CNT_W   = $clog2(NODES + 1);
    localparam int GADDR_W = $clog2(NODES * ALPHABET);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int RCNT_W  = $clog2(RESULT_CAP + 1);
    localparam int SYM_W   = 5;
    localparam int ACT_W   = 3;
    localparam int ID_W    = 16;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 32;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [GADDR_W-1:0] t_gaddr;
    typedef logic [SYM_W-1:0]   t_sym;
    typedef logic [ACT_W-1:0]   t_act;
    typedef logic [ID_W-1:0]    t_id;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [POS_W-1:0]   t_pos;

    localparam t_act ACT_CLEAR = 3'd0;
    localparam t_act ACT_SYM   = 3'd1;
    localparam t_act ACT_END   = 3'd2;
    localparam t_act ACT_BUILD = 3'd3;
    localparam t_act ACT_SCAN  = 3'd4;
    localparam t_act ACT_TEXT  = 3'd5;

    localparam t_kind KIND_MATCH  = 2'd0;
    localparam t_kind KIND_BUILT  = 2'd1;
    localparam t_kind KIND_ACCEPT = 2'd2;
    localparam t_kind KIND_REJECT = 2'd3;

endpackage

/* hw/rtl/acm_ram.sv */
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/aho_corasick_matcher_core.sv */
// text symbol: goto lookup, output-link select, output-link walk, then flush of a pending match
// pattern symbol: goto lookup on an existing edge; a new node also needs its goto row zeroed
// build: root row scan, then per node a queue pop, fail read, column pass; all on one goto port
// one transaction at a time; the goto memory port and its shared row*26+col address unit set rate
// reset (synchronous, active low) and clear all run a pass zeroing the root goto row;
// no input is taken during that pass, configuration writes are always taken
module aho_corasick_matcher_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_report_mode,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  acm_pkg::t_act         i_action,
    input  acm_pkg::t_sym         i_symbol,
    input  acm_pkg::t_id          i_pattern_id,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output acm_pkg::t_kind        o_kind,
    output acm_pkg::t_id          o_match_id,
    output acm_pkg::t_node        o_match_node,
    output acm_pkg::t_pos         o_text_position,
    output logic                  o_final_report
);
    import acm_pkg::*;

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISP     = 5'd2;
    localparam logic [4:0] S_INS_CHK  = 5'd3;
    localparam logic [4:0] S_INS_INIT = 5'd4;
    localparam logic [4:0] S_INS_LINK = 5'd5;
    localparam logic [4:0] S_BR_RD    = 5'd6;
    localparam logic [4:0] S_BR_CHK   = 5'd7;
    localparam logic [4:0] S_B_POP    = 5'd8;
    localparam logic [4:0] S_B_U      = 5'd9;
    localparam logic [4:0] S_B_FU     = 5'd10;
    localparam logic [4:0] S_B_C0     = 5'd11;
    localparam logic [4:0] S_B_C1     = 5'd12;
    localparam logic [4:0] S_B_C2     = 5'd13;
    localparam logic [4:0] S_B_C3     = 5'd14;
    localparam logic [4:0] S_T_NODE   = 5'd15;
    localparam logic [4:0] S_T_SEL    = 5'd16;
    localparam logic [4:0] S_W_RD     = 5'd17;
    localparam logic [4:0] S_W_CHK    = 5'd18;
    localparam logic [4:0] S_FLUSH    = 5'd19;

    localparam t_sym   COL_LAST = SYM_W'(ALPHABET - 1);
    localparam t_gaddr ALPHA_G  = GADDR_W'(ALPHABET);

    logic [4:0]         r_state, n_state;
    t_sym               r_col, n_col;
    t_cnt               r_count, n_count;
    t_node              r_cursor, n_cursor;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_failed, n_failed;
    t_node              r_cur, n_cur;
    t_pos               r_scan, n_scan;
    logic               r_built, n_built;
    logic               r_mode;
    t_act               r_act, n_act;
    t_sym               r_sym, n_sym;
    t_id                r_pid, n_pid;
    t_cnt               r_head, n_head;
    t_cnt               r_tail, n_tail;
    t_node              r_u, n_u;
    t_node              r_fu, n_fu;
    t_node              r_child, n_child;
    t_node              r_via, n_via;
    t_node              r_t, n_t;
    logic [RCNT_W-1:0]  r_n, n_n;
    t_pos               r_pos, n_pos;
    logic               r_p_valid, n_p_valid;
    t_kind              r_p_kind, n_p_kind;
    t_id                r_p_id, n_p_id;
    t_node              r_p_node, n_p_node;
    t_pos               r_p_pos, n_p_pos;
    logic               r_o_valid, n_o_valid;
    t_kind              r_o_kind, n_o_kind;
    t_id                r_o_id, n_o_id;
    t_node              r_o_node, n_o_node;
    t_pos               r_o_pos, n_o_pos;
    logic               r_o_final, n_o_final;

    // shared goto address unit: row * ALPHABET + col
    t_node  w_row;
    t_sym   w_col;
    t_gaddr w_gaddr;
    assign w_gaddr = GADDR_W'(w_row) * ALPHA_G + GADDR_W'(w_col);

    logic  g_we;
    t_node g_wdata, g_rdata;
    logic  f_we;
    t_node f_waddr, f_wdata, f_raddr, f_rdata;
    logic  o_we;
    t_node o_waddr, o_wdata, o_raddr, o_rdata;
    logic  e_we, e_wdata, e_rdata;
    t_node e_waddr, e_raddr;
    logic  s_we;
    t_node s_waddr, s_raddr;
    t_id   s_wdata, s_rdata;
    logic  c_we, c_wdata, c_rdata;
    t_node c_waddr, c_raddr;
    logic  q_we;
    t_node q_waddr, q_wdata, q_raddr, q_rdata;

    acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES * ALPHABET)) u_goto (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(w_gaddr), .i_wdata(g_wdata),
        .i_raddr(w_gaddr), .o_rdata(g_rdata)
    );
    acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );
    acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_olink (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_raddr(o_raddr), .o_rdata(o_rdata)
    );
    acm_ram #(.WIDTH(1), .DEPTH(NODES)) u_ends (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    acm_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_ids (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    acm_ram #(.WIDTH(1), .DEPTH(NODES)) u_used (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
    acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    logic  w_out_free, w_sym_ok, w_emit;
    t_node w_count_node;
    assign w_out_free   = !r_o_valid || i_out_ready;
    assign w_sym_ok     = r_sym < SYM_W'(ALPHABET);
    assign w_emit       = !r_mode || !c_rdata;
    assign w_count_node = r_count[NODE_W-1:0];

    always_comb begin
        n_state = r_state;   n_col = r_col;       n_count = r_count;
        n_cursor = r_cursor; n_depth = r_depth;   n_failed = r_failed;
        n_cur = r_cur;       n_scan = r_scan;     n_built = r_built;
        n_act = r_act;       n_sym = r_sym;       n_pid = r_pid;
        n_head = r_head;     n_tail = r_tail;     n_u = r_u;
        n_fu = r_fu;         n_child = r_child;   n_via = r_via;
        n_t = r_t;           n_n = r_n;           n_pos = r_pos;
        n_p_valid = r_p_valid; n_p_kind = r_p_kind; n_p_id = r_p_id;
        n_p_node = r_p_node;   n_p_pos = r_p_pos;
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_kind = r_o_kind; n_o_id = r_o_id; n_o_node = r_o_node;
        n_o_pos = r_o_pos;   n_o_final = r_o_final;

        w_row = '0;   w_col = r_col;
        g_we = 1'b0;  g_wdata = '0;
        f_we = 1'b0;  f_waddr = '0; f_wdata = '0; f_raddr = q_rdata;
        o_we = 1'b0;  o_waddr = '0; o_wdata = '0; o_raddr = r_t;
        e_we = 1'b0;  e_waddr = '0; e_wdata = 1'b0; e_raddr = g_rdata;
        s_we = 1'b0;  s_waddr = '0; s_wdata = '0; s_raddr = r_t;
        c_we = 1'b0;  c_waddr = '0; c_wdata = 1'b0; c_raddr = r_t;
        q_we = 1'b0;  q_waddr = r_tail[NODE_W-1:0]; q_wdata = '0;
        q_raddr = r_head[NODE_W-1:0];

        unique case (r_state)
            S_CLR: begin
                g_we = 1'b1;
                if (r_col == '0) begin
                    e_we = 1'b1;
                    o_we = 1'b1;
                end
                if (r_col == COL_LAST) begin
                    n_col   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_col = r_col + SYM_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act   = i_action;
                    n_sym   = i_symbol;
                    n_pid   = i_pattern_id;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                unique case (r_act)
                    ACT_CLEAR: begin
                        n_count  = CNT_W'(1);
                        n_cursor = '0;
                        n_depth  = '0;
                        n_failed = 1'b0;
                        n_cur    = '0;
                        n_scan   = '0;
                        n_built  = 1'b0;
                        n_col    = '0;
                        n_state  = S_CLR;
                    end
                    ACT_SYM: begin
                        w_row = r_cursor;
                        w_col = r_sym;
                        if (!r_failed) begin
                            if (r_built || !w_sym_ok ||
                                r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                                n_failed = 1'b1;
                            end else begin
                                n_state = S_INS_CHK;
                            end
                        end
                    end
                    ACT_END: begin
                        n_p_valid = 1'b1;
                        n_p_id    = '0;
                        n_p_pos   = '0;
                        if (!r_failed && !r_built && r_depth != '0) begin
                            e_we      = 1'b1;
                            e_waddr   = r_cursor;
                            e_wdata   = 1'b1;
                            s_we      = 1'b1;
                            s_waddr   = r_cursor;
                            s_wdata   = r_pid;
                            n_p_kind  = KIND_ACCEPT;
                            n_p_node  = r_cursor;
                        end else begin
                            n_p_kind  = KIND_REJECT;
                            n_p_node  = '0;
                        end
                        n_cursor = '0;
                        n_depth  = '0;
                        n_failed = 1'b0;
                        n_state  = S_FLUSH;
                    end
                    ACT_BUILD: begin
                        n_cursor = '0;
                        n_depth  = '0;
                        n_failed = 1'b0;
                        if (r_built) begin
                            n_p_valid = 1'b1;
                            n_p_kind  = KIND_BUILT;
                            n_p_id    = '0;
                            n_p_node  = '0;
                            n_p_pos   = '0;
                            n_state   = S_FLUSH;
                        end else begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_col   = '0;
                            n_state = S_BR_RD;
                        end
                    end
                    ACT_SCAN: begin
                        n_cur  = '0;
                        n_scan = '0;
                    end
                    ACT_TEXT: begin
                        w_row = r_cur;
                        w_col = r_sym;
                        if (r_built) begin
                            n_pos  = r_scan;
                            n_scan = r_scan + POS_W'(1);
                            n_n    = '0;
                            if (w_sym_ok) begin
                                n_state = S_T_NODE;
                            end else begin
                                n_cur = '0;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (g_rdata != '0) begin
                    n_cursor = g_rdata;
                    n_depth  = r_depth + DEPTH_W'(1);
                    n_state  = S_IDLE;
                end else if (r_count >= CNT_W'(NODES)) begin
                    n_failed = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_col   = '0;
                    n_state = S_INS_INIT;
                end
            end
            S_INS_INIT: begin
                // zero the new node's goto row, its links and marks on the first beat
                w_row = w_count_node;
                g_we  = 1'b1;
                if (r_col == '0) begin
                    f_we = 1'b1; f_waddr = w_count_node;
                    o_we = 1'b1; o_waddr = w_count_node;
                    e_we = 1'b1; e_waddr = w_count_node;
                    s_we = 1'b1; s_waddr = w_count_node;
                    c_we = 1'b1; c_waddr = w_count_node;
                end
                if (r_col == COL_LAST) begin
                    n_state = S_INS_LINK;
                end else begin
                    n_col = r_col + SYM_W'(1);
                end
            end
            S_INS_LINK: begin
                w_row    = r_cursor;
                w_col    = r_sym;
                g_we     = 1'b1;
                g_wdata  = w_count_node;
                n_cursor = w_count_node;
                n_count  = r_count + CNT_W'(1);
                n_depth  = r_depth + DEPTH_W'(1);
                n_state  = S_IDLE;
            end
            S_BR_RD: begin
                n_state = S_BR_CHK;
            end
            S_BR_CHK: begin
                if (g_rdata != '0 && r_tail < CNT_W'(NODES)) begin
                    f_we    = 1'b1; f_waddr = g_rdata;
                    o_we    = 1'b1; o_waddr = g_rdata;
                    q_we    = 1'b1; q_wdata = g_rdata;
                    n_tail  = r_tail + CNT_W'(1);
                end
                if (r_col == COL_LAST) begin
                    n_state = S_B_POP;
                end else begin
                    n_col   = r_col + SYM_W'(1);
                    n_state = S_BR_RD;
                end
            end
            S_B_POP: begin
                if (r_head < r_tail) begin
                    n_state = S_B_U;
                end else begin
                    n_built   = 1'b1;
                    n_p_valid = 1'b1;
                    n_p_kind  = KIND_BUILT;
                    n_p_id    = '0;
                    n_p_node  = '0;
                    n_p_pos   = '0;
                    n_state   = S_FLUSH;
                end
            end
            S_B_U: begin
                n_u     = q_rdata;
                n_head  = r_head + CNT_W'(1);
                n_state = S_B_FU;
            end
            S_B_FU: begin
                n_fu    = f_rdata;
                n_col   = '0;
                n_state = S_B_C0;
            end
            S_B_C0: begin
                w_row   = r_u;
                n_state = S_B_C1;
            end
            S_B_C1: begin
                w_row   = r_fu;
                n_child = g_rdata;
                n_state = S_B_C2;
            end
            S_B_C2: begin
                if (r_child == '0) begin
                    // missing edge takes the failure node's transition
                    w_row   = r_u;
                    g_we    = 1'b1;
                    g_wdata = g_rdata;
                    if (r_col == COL_LAST) begin
                        n_state = S_B_POP;
                    end else begin
                        n_col   = r_col + SYM_W'(1);
                        n_state = S_B_C0;
                    end
                end else begin
                    f_we    = 1'b1;
                    f_waddr = r_child;
                    f_wdata = g_rdata;
                    o_raddr = g_rdata;
                    n_via   = g_rdata;
                    n_state = S_B_C3;
                end
            end
            S_B_C3: begin
                o_we    = 1'b1;
                o_waddr = r_child;
                o_wdata = e_rdata ? r_via : o_rdata;
                if (r_tail < CNT_W'(NODES)) begin
                    q_we    = 1'b1;
                    q_wdata = r_child;
                    n_tail  = r_tail + CNT_W'(1);
                end
                if (r_col == COL_LAST) begin
                    n_state = S_B_POP;
                end else begin
                    n_col   = r_col + SYM_W'(1);
                    n_state = S_B_C0;
                end
            end
            S_T_NODE: begin
                n_cur   = g_rdata;
                o_raddr = g_rdata;
                n_state = S_T_SEL;
            end
            S_T_SEL: begin
                n_t     = e_rdata ? r_cur : o_rdata;
                n_state = S_W_RD;
            end
            S_W_RD: begin
                if (r_t == '0 || r_n == RCNT_W'(RESULT_CAP)) begin
                    n_state = r_p_valid ? S_FLUSH : S_IDLE;
                end else begin
                    n_state = S_W_CHK;
                end
            end
            S_W_CHK: begin
                // hold a found match back until the next one shows it is not the last
                if (!(w_emit && r_p_valid && !w_out_free)) begin
                    if (w_emit) begin
                        if (r_p_valid) begin
                            n_o_valid = 1'b1;
                            n_o_kind  = r_p_kind;
                            n_o_id    = r_p_id;
                            n_o_node  = r_p_node;
                            n_o_pos   = r_p_pos;
                            n_o_final = 1'b0;
                        end
                        n_p_valid = 1'b1;
                        n_p_kind  = KIND_MATCH;
                        n_p_id    = s_rdata;
                        n_p_node  = r_t;
                        n_p_pos   = r_pos;
                        n_n       = r_n + RCNT_W'(1);
                        if (r_mode) begin
                            c_we    = 1'b1;
                            c_waddr = r_t;
                            c_wdata = 1'b1;
                        end
                    end
                    n_t     = o_rdata;
                    n_state = S_W_RD;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = r_p_kind;
                    n_o_id    = r_p_id;
                    n_o_node  = r_p_node;
                    n_o_pos   = r_p_pos;
                    n_o_final = 1'b1;
                    n_p_valid = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_col     <= '0;
            r_count   <= CNT_W'(1);
            r_cursor  <= '0;
            r_depth   <= '0;
            r_failed  <= 1'b0;
            r_cur     <= '0;
            r_scan    <= '0;
            r_built   <= 1'b0;
            r_mode    <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_n       <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_depth   <= n_depth;
            r_failed  <= n_failed;
            r_cur     <= n_cur;
            r_scan    <= n_scan;
            r_built   <= n_built;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_n       <= n_n;
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                r_mode <= i_report_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_sym    <= n_sym;
        r_pid    <= n_pid;
        r_u      <= n_u;
        r_fu     <= n_fu;
        r_child  <= n_child;
        r_via    <= n_via;
        r_t      <= n_t;
        r_pos    <= n_pos;
        r_p_kind <= n_p_kind;
        r_p_id   <= n_p_id;
        r_p_node <= n_p_node;
        r_p_pos  <= n_p_pos;
        r_o_kind <= n_o_kind;
        r_o_id   <= n_o_id;
        r_o_node <= n_o_node;
        r_o_pos  <= n_o_pos;
        r_o_final <= n_o_final;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_match_id      = r_o_id;
    assign o_match_node    = r_o_node;
    assign o_text_position = r_o_pos;
    assign o_final_report  = r_o_final;

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_p_valid)
        else $error("pending result left behind at idle");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(1)) && (r_count <= CNT_W'(NODES)))
        else $error("node count out of range");
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_DEPTH))
        else $error("insert depth beyond limit");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RCNT_W'(RESULT_CAP))
        else $error("too many results for one symbol");
`endif
endmodule
